@@ hw/rtl/ialu_pkg.sv @@
// Shared types and codes for the integer ALU with sequence splay.
`default_nettype none
package ialu_pkg;

	// Port field widths, fixed by the interface
	localparam int DATA_W   = 32;
	localparam int KIND_W   = 4;
	localparam int STATUS_W = 2;

	// Opcodes
	localparam logic [KIND_W-1:0] KIND_ADD   = 4'd0;
	localparam logic [KIND_W-1:0] KIND_SUB   = 4'd1;
	localparam logic [KIND_W-1:0] KIND_MUL   = 4'd2;
	localparam logic [KIND_W-1:0] KIND_DIV   = 4'd3;
	localparam logic [KIND_W-1:0] KIND_MOD   = 4'd4;
	localparam logic [KIND_W-1:0] KIND_INC   = 4'd5;
	localparam logic [KIND_W-1:0] KIND_DEC   = 4'd6;
	localparam logic [KIND_W-1:0] KIND_ABS   = 4'd7;
	localparam logic [KIND_W-1:0] KIND_SPLAY = 4'd8;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DIV0  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADOP = 2'd2;
	localparam logic [STATUS_W-1:0] ST_CLAMP = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] operand_a;
		logic [DATA_W-1:0] operand_b;
		logic [DATA_W-1:0] operand_c;
	} in_t;

	typedef struct packed {
		logic [DATA_W-1:0]   value;
		logic [STATUS_W-1:0] status;
		logic                last;
	} out_t;

endpackage
`default_nettype wire

@@ hw/rtl/integer_alu_with_sequence_splay.sv @@
// Top level of the integer ALU with sequence splay.
`default_nettype none
// Integer ALU on WIDTH-bit operands (low WIDTH bits of each 32-bit operand
// field are used, results are zero-extended to 32 bits). One item is in work
// at a time. Add, sub, inc, dec, abs, unknown opcodes and divide by zero are
// settled in the execute state and go straight to the output register; mul
// is started, then built by the bit-serial shift-and-add unit that retires
// one multiplier bit per cycle, then emitted; div and mod are loaded, then
// built by the restoring divider that retires one quotient bit per cycle,
// then given a sign fixup and emitted. Splay emits its n result beats, one
// wide add per beat, back to back while out_ready stays high; a count of
// zero (or negative in signed mode) emits nothing and frees the block. A
// count above MAX_SPLAY is clamped to MAX_SPLAY and every beat of that run
// carries status 3. The result sits in an output register, so a new input
// beat is taken while the previous result still waits for out_ready.
// signed_mode (reset 1) selects two's complement with truncating division;
// write it via cfg_we only while the block is idle.
module integer_alu_with_sequence_splay #(
	parameter int WIDTH     = 32,
	parameter int MAX_SPLAY = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire ialu_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ialu_pkg::out_t      out_data,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata
);

	localparam int DW    = ialu_pkg::DATA_W;
	localparam int CNT_W = $clog2(MAX_SPLAY + 1);

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_SPLAY} state_t;

	state_t           state_q;
	ialu_pkg::in_t    op_q;
	logic             signed_mode_q;
	logic             out_valid_q;
	ialu_pkg::out_t   out_q;
	logic [WIDTH-1:0] acc_q;
	logic [CNT_W-1:0] remain_q;
	logic             clamp_q;

	logic [WIDTH-1:0] a_w;
	logic [WIDTH-1:0] b_w;
	logic [WIDTH-1:0] c_w;
	logic             slot_free;
	logic             mul_start;
	logic             div_start;
	logic             mul_busy;
	logic             div_busy;
	logic [WIDTH-1:0] prod;
	logic [WIDTH-1:0] quot;
	logic [WIDTH-1:0] rem;

	// Shared adder for add, sub, inc, dec and abs
	logic [WIDTH-1:0] add_x;
	logic [WIDTH-1:0] add_y;
	logic             add_cin;
	logic [WIDTH-1:0] add_sum;

	// Splay count after sign check and clamp
	logic             splay_neg;
	logic             splay_big;
	logic [CNT_W-1:0] splay_n;

	assign a_w = op_q.operand_a[WIDTH-1:0];
	assign b_w = op_q.operand_b[WIDTH-1:0];
	assign c_w = op_q.operand_c[WIDTH-1:0];

	// Output register frees up when empty or being drained this cycle
	assign slot_free = !out_valid_q || out_ready;

	assign mul_start = (state_q == S_EXEC) && (op_q.kind == ialu_pkg::KIND_MUL);
	assign div_start = (state_q == S_EXEC) && (b_w != '0) &&
		((op_q.kind == ialu_pkg::KIND_DIV) || (op_q.kind == ialu_pkg::KIND_MOD));

	always_comb begin
		add_x   = a_w;
		add_y   = '0;
		add_cin = 1'b0;
		case (op_q.kind)
			ialu_pkg::KIND_ADD: add_y = b_w;
			ialu_pkg::KIND_SUB: begin
				add_y   = ~b_w;
				add_cin = 1'b1;
			end
			ialu_pkg::KIND_INC: add_cin = 1'b1;
			ialu_pkg::KIND_DEC: add_y = '1;
			ialu_pkg::KIND_ABS: begin
				// Negate only a negative value in signed mode
				if (signed_mode_q && a_w[WIDTH-1]) begin
					add_x   = '0;
					add_y   = ~a_w;
					add_cin = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign add_sum = add_x + add_y + WIDTH'(add_cin);

	assign splay_neg = signed_mode_q && b_w[WIDTH-1];
	assign splay_big = !splay_neg && (b_w > WIDTH'(MAX_SPLAY));
	assign splay_n   = splay_neg ? '0 :
		(splay_big ? CNT_W'(MAX_SPLAY) : b_w[CNT_W-1:0]);

	ialu_mul #(
		.WIDTH(WIDTH)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.mcand (a_w),
		.mplier(b_w),
		.busy  (mul_busy),
		.prod  (prod)
	);

	ialu_div #(
		.WIDTH(WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.sgn     (signed_mode_q),
		.dividend(a_w),
		.divisor (b_w),
		.busy    (div_busy),
		.quot    (quot),
		.rem     (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b1;
		end else if (cfg_we) begin
			signed_mode_q <= cfg_wdata;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			remain_q    <= '0;
			clamp_q     <= 1'b0;
		end else begin
			// Drop the held beat once taken; an emit below overrides this
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q.kind)
						ialu_pkg::KIND_MUL: state_q <= S_MUL;
						ialu_pkg::KIND_DIV, ialu_pkg::KIND_MOD: begin
							if (b_w != '0) begin
								state_q <= S_DIV;
							end else if (slot_free) begin
								out_valid_q  <= 1'b1;
								out_q.value  <= '0;
								out_q.status <= ialu_pkg::ST_DIV0;
								out_q.last   <= 1'b1;
								state_q      <= S_IDLE;
							end
						end
						ialu_pkg::KIND_SPLAY: begin
							// Empty run frees the block at once
							acc_q    <= a_w;
							remain_q <= splay_n;
							clamp_q  <= splay_big;
							state_q  <= (splay_n == '0) ? S_IDLE : S_SPLAY;
						end
						ialu_pkg::KIND_ADD, ialu_pkg::KIND_SUB, ialu_pkg::KIND_INC,
						ialu_pkg::KIND_DEC, ialu_pkg::KIND_ABS: begin
							if (slot_free) begin
								out_valid_q  <= 1'b1;
								out_q.value  <= DW'(add_sum);
								out_q.status <= ialu_pkg::ST_OK;
								out_q.last   <= 1'b1;
								state_q      <= S_IDLE;
							end
						end
						default: begin
							if (slot_free) begin
								out_valid_q  <= 1'b1;
								out_q.value  <= '0;
								out_q.status <= ialu_pkg::ST_BADOP;
								out_q.last   <= 1'b1;
								state_q      <= S_IDLE;
							end
						end
					endcase
				end
				S_MUL: begin
					if (!mul_busy && slot_free) begin
						out_valid_q  <= 1'b1;
						out_q.value  <= DW'(prod);
						out_q.status <= ialu_pkg::ST_OK;
						out_q.last   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_DIV: begin
					if (!div_busy && slot_free) begin
						out_valid_q  <= 1'b1;
						out_q.value  <= (op_q.kind == ialu_pkg::KIND_DIV) ?
							DW'(quot) : DW'(rem);
						out_q.status <= ialu_pkg::ST_OK;
						out_q.last   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_SPLAY: begin
					// One term per beat: emit, then advance by the step
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_q.value  <= DW'(acc_q);
						out_q.status <= clamp_q ? ialu_pkg::ST_CLAMP : ialu_pkg::ST_OK;
						out_q.last   <= (remain_q == CNT_W'(1));
						acc_q        <= acc_q + c_w;
						remain_q     <= remain_q - 1'b1;
						if (remain_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the accepted item for the whole operation
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= in_data;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/ialu_mul.sv @@
// Bit-serial shift-and-add multiplier, low WIDTH bits of the product.
`default_nettype none
module ialu_mul #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] mcand,
	input  wire logic [WIDTH-1:0] mplier,
	output logic                  busy,
	output logic      [WIDTH-1:0] prod
);

	localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic             busy_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] mcand_q;
	logic [WIDTH-1:0] mplier_q;
	logic [WIDTH-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(WIDTH - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// One multiplier bit per cycle: add the shifted multiplicand where it is set
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[WIDTH-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[WIDTH-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

@@ hw/rtl/ialu_div.sv @@
// Restoring divider, one quotient bit per cycle, with C-style signed fixup.
`default_nettype none
module ialu_div #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             sgn,
	input  wire logic [WIDTH-1:0] dividend,
	input  wire logic [WIDTH-1:0] divisor,
	output logic                  busy,
	output logic      [WIDTH-1:0] quot,
	output logic      [WIDTH-1:0] rem
);

	localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

	dstate_t          state_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvs_q;
	logic             qneg_q;
	logic             rneg_q;

	logic             a_neg;
	logic             b_neg;
	logic [WIDTH:0]   shifted;
	logic [WIDTH+1:0] trial;

	assign a_neg   = sgn & dividend[WIDTH-1];
	assign b_neg   = sgn & divisor[WIDTH-1];
	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_RUN;
						cnt_q   <= CW'(WIDTH - 1);
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					// Work on magnitudes; signs come back in the fixup cycle
					quo_q  <= a_neg ? (~dividend + 1'b1) : dividend;
					dvs_q  <= b_neg ? (~divisor + 1'b1) : divisor;
					rem_q  <= '0;
					qneg_q <= a_neg ^ b_neg;
					rneg_q <= a_neg;
				end
			end
			D_RUN: begin
				rem_q <= trial[WIDTH+1] ? shifted[WIDTH-1:0] : trial[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], ~trial[WIDTH+1]};
			end
			D_FIX: begin
				if (qneg_q) begin
					quo_q <= ~quo_q + 1'b1;
				end
				if (rneg_q) begin
					rem_q <= ~rem_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != D_IDLE);
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

@@ hw/rtl/ialu_checker.sv @@
// Port-level checks for the integer ALU, bound to the top level.
`default_nettype none
module ialu_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire ialu_pkg::out_t out_data
);

	// One item at a time: an input beat closes the input side next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an input beat");

	// Divide by zero and unknown opcodes report a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ialu_pkg::ST_DIV0 ||
			out_data.status == ialu_pkg::ST_BADOP) |-> out_data.value == '0)
		else $error("error status with nonzero value");

	// Single-result errors always close their item
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ialu_pkg::ST_DIV0 ||
			out_data.status == ialu_pkg::ST_BADOP) |-> out_data.last)
		else $error("error result without last");

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

endmodule

bind integer_alu_with_sequence_splay ialu_checker u_ialu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
`default_nettype wire
